// File: rtl/ippm_pkg.sv
// Package for the interval paint priority match block.
// Holds field widths, the action codes and the structs shared by the table and top level.
// No dependencies.
`timescale 1ns / 1ps

package ippm_pkg;

    localparam int unsigned MAX_INTERVALS_DEF = 16;

    localparam int unsigned POS_W   = 10;
    localparam int unsigned COLOR_W = 16;
    localparam int unsigned LEN_W   = 11;
    localparam int unsigned ACT_W   = 2;

    localparam logic [LEN_W-1:0] LINE_LEN_RESET = 11'd1024;

    // Input beat: range_start, range_end, paint_color, position (46 bits, padded to 48).
    localparam int unsigned IN_DATA_W  = 48;
    // Result beat: pixel_color, covered, table_full, out_of_line (19 bits, padded to 24).
    localparam int unsigned OUT_DATA_W = 24;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_QUERY  = 2'd1,
        ACT_CLEAR  = 2'd2
    } action_t;

    // Table update for one beat.
    typedef struct packed {
        logic               append;
        logic               clear;
        logic [POS_W-1:0]   range_start;
        logic [POS_W-1:0]   range_end;
        logic [COLOR_W-1:0] paint_color;
    } table_cmd_t;

    // Lookup answer from the table, valid in the same cycle as the command.
    typedef struct packed {
        logic               hit;
        logic [COLOR_W-1:0] color;
        logic               full;
    } lookup_t;

endpackage

// File: rtl/ippm_table.sv
// Interval table: stores start, end and color per entry plus the fill count,
// and finds the newest entry that covers a position. Depends on ippm_pkg.
`timescale 1ns / 1ps

module ippm_table #(
    parameter int unsigned MAX_INTERVALS = ippm_pkg::MAX_INTERVALS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_en,
    input  ippm_pkg::table_cmd_t            cmd,
    input  logic [ippm_pkg::POS_W-1:0]      position,
    output ippm_pkg::lookup_t               lookup
);

    localparam int unsigned CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam int unsigned IDX_W = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);

    logic [ippm_pkg::POS_W-1:0]   starts_reg [MAX_INTERVALS];
    logic [ippm_pkg::POS_W-1:0]   ends_reg   [MAX_INTERVALS];
    logic [ippm_pkg::COLOR_W-1:0] colors_reg [MAX_INTERVALS];
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         full;
    logic                         wr_en;

    assign full  = (count_reg == CNT_MAX);
    assign wr_en = cmd_en && cmd.append && !full;

    always_comb
    begin
        count_next = count_reg;
        if (cmd_en && cmd.clear)
        begin
            count_next = '0;
        end
        else if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            starts_reg[count_reg[IDX_W-1:0]] <= cmd.range_start;
            ends_reg[count_reg[IDX_W-1:0]]   <= cmd.range_end;
            colors_reg[count_reg[IDX_W-1:0]] <= cmd.paint_color;
        end
    end

    // Compare every live entry in parallel; a higher index is newer and wins.
    always_comb
    begin
        lookup.hit   = 1'b0;
        lookup.color = '0;
        lookup.full  = full;
        for (int k = 0; k < MAX_INTERVALS; k++)
        begin
            if ((CNT_W'(k) < count_reg) &&
                (starts_reg[k] <= position) && (position <= ends_reg[k]))
            begin
                lookup.hit   = 1'b1;
                lookup.color = colors_reg[k];
            end
        end
    end

endmodule

// File: rtl/interval_paint_priority_match.sv
// Top level of the interval paint priority match block.
// Holds the input and result registers and the line length register; uses ippm_pkg, ippm_table.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tuser: action; tdata: start, end, color, position
//  m_*     | out | m_tvalid/m_tready  | tdata: pixel_color, covered, table_full, out_of_line
//  cfg_*   | in  | cfg_valid/cfg_ready| cfg_data: line_length (always ready)
//
// One beat per cycle sustained while m_tready stays high; a beat passes through the input
// register, then the result register, before its result shows on m_tvalid. The parallel
// compare over all table entries lies between those two registers.
// Reset (rst_n low, asynchronous) empties the table and restores line_length to 1024.
// A stalled result holds in the result register; the input register still takes one
// more beat, then s_tready drops until m_tready frees the result register.
`timescale 1ns / 1ps

module interval_paint_priority_match #(
    parameter int unsigned MAX_INTERVALS = ippm_pkg::MAX_INTERVALS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [9:0] range_start, [19:10] range_end, [35:20] paint_color, [45:36] position
    input  logic [ippm_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] action
    input  logic [ippm_pkg::ACT_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [15:0] pixel_color, [16] covered, [17] table_full, [18] out_of_line
    output logic [ippm_pkg::OUT_DATA_W-1:0]    m_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ippm_pkg::LEN_W-1:0]         cfg_data
);

    localparam int unsigned POS_W   = ippm_pkg::POS_W;
    localparam int unsigned COLOR_W = ippm_pkg::COLOR_W;
    localparam int unsigned LEN_W   = ippm_pkg::LEN_W;

    // Input register
    logic                    in_valid_reg;
    ippm_pkg::action_t       in_action_reg;
    logic [POS_W-1:0]        in_start_reg;
    logic [POS_W-1:0]        in_end_reg;
    logic [COLOR_W-1:0]      in_color_reg;
    logic [POS_W-1:0]        in_pos_reg;

    // Result register
    logic                    out_valid_reg;
    logic [COLOR_W-1:0]      out_color_reg;
    logic                    out_covered_reg;
    logic                    out_full_reg;
    logic                    out_ool_reg;
    logic [COLOR_W-1:0]      out_color_next;
    logic                    out_covered_next;
    logic                    out_full_next;
    logic                    out_ool_next;

    logic [LEN_W-1:0]        line_len_reg;

    logic                    advance;
    logic                    s_take;
    ippm_pkg::table_cmd_t    cmd;
    ippm_pkg::lookup_t       lookup;

    // Advance the held beat whenever the result register is empty or being drained.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_len_reg <= ippm_pkg::LINE_LEN_RESET;
        end
        else if (cfg_valid)
        begin
            line_len_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    // Payload of the input register: capture on every taken beat.
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            in_action_reg <= ippm_pkg::action_t'(s_tuser);
            in_start_reg  <= s_tdata[9:0];
            in_end_reg    <= s_tdata[19:10];
            in_color_reg  <= s_tdata[35:20];
            in_pos_reg    <= s_tdata[45:36];
        end
    end

    always_comb
    begin
        cmd.append      = (in_action_reg == ippm_pkg::ACT_APPEND);
        cmd.clear       = (in_action_reg == ippm_pkg::ACT_CLEAR);
        cmd.range_start = in_start_reg;
        cmd.range_end   = in_end_reg;
        cmd.paint_color = in_color_reg;
    end

    ippm_table #(
        .MAX_INTERVALS (MAX_INTERVALS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_en   (advance),
        .cmd      (cmd),
        .position (in_pos_reg),
        .lookup   (lookup)
    );

    // Form the result. The lookup sees the table as it stood before this beat.
    always_comb
    begin
        out_color_next   = '0;
        out_covered_next = 1'b0;
        out_full_next    = 1'b0;
        out_ool_next     = 1'b0;
        case (in_action_reg)
            ippm_pkg::ACT_APPEND:
            begin
                out_full_next = lookup.full;
            end
            ippm_pkg::ACT_QUERY:
            begin
                if ({1'b0, in_pos_reg} >= line_len_reg)
                begin
                    out_ool_next = 1'b1;
                end
                else
                begin
                    out_covered_next = lookup.hit;
                    out_color_next   = lookup.color;
                end
            end
            default:
            begin
                // Clear and the unused code give an all-zero result.
                out_full_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_color_reg   <= out_color_next;
            out_covered_reg <= out_covered_next;
            out_full_reg    <= out_full_next;
            out_ool_reg     <= out_ool_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_ool_reg, out_full_reg, out_covered_reg, out_color_reg};

endmodule

// File: rtl/ippm_checker.sv
// Port-level checks for interval_paint_priority_match, bound to the top level.
// Depends on ippm_pkg for widths.
`timescale 1ns / 1ps

module ippm_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [ippm_pkg::OUT_DATA_W-1:0] m_tdata
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // With the result register empty the input side must be open.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while result register empty");

    // An uncovered result carries color zero.
    a_uncovered_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[16] |-> m_tdata[15:0] == 16'd0)
        else $error("color without cover");

    // The three flags never combine.
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $countones(m_tdata[18:16]) <= 1)
        else $error("conflicting result flags");

endmodule

bind interval_paint_priority_match ippm_checker u_ippm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
